### rtl/ptd_pkg.sv
// Package for the capture-trace deframer: phase codes, result kinds,
// configuration indexes, magic constants and the result item struct.
// No dependencies; used by ptd_parser and pcap_trace_deframer_unit.
`default_nettype none

package ptd_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_FILE  = 3'd0,
        PH_REC   = 3'd1,
        PH_COPY  = 3'd2,
        PH_SKIP  = 3'd3,
        PH_STUCK = 3'd4
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_COPY = 2'd0;
    localparam logic [1:0] CFG_FILL     = 2'd1;

    // Header sizes
    localparam logic [4:0] FILE_HEADER_BYTES   = 5'd24;
    localparam logic [4:0] RECORD_HEADER_BYTES = 5'd16;
    localparam logic [4:0] MAGIC_LAST_INDEX    = 5'd3;

    // File magics, read least significant byte first
    localparam logic [31:0] MAGIC_MICRO      = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_NANO       = 32'ha1b23c4d;
    localparam logic [31:0] MAGIC_MICRO_SWAP = 32'hd4c3b2a1;
    localparam logic [31:0] MAGIC_NANO_SWAP  = 32'h4d3cb2a1;

    localparam logic [15:0] MAX_COPY_RESET = 16'd2048;
    localparam logic [7:0]  FILL_RESET     = 8'd0;

    // Configuration seen by the parser
    typedef struct packed {
        logic [15:0] max_copy_length;
        logic [7:0]  fill_byte;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  payload_byte;
        logic [15:0] packet_length;
        logic [15:0] pad_length;
        logic [7:0]  pad_value;
        logic        swapped_order;
        logic        nano_stamps;
        logic        last_of_run;
    } res_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

### rtl/ptd_parser.sv
// Parser core of the capture-trace deframer: phase state and counters,
// and the up to two result items produced by one accepted byte.
// Depends on ptd_pkg.
`default_nettype none

module ptd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    file_byte,
    input  wire logic          file_start,
    input  wire ptd_pkg::cfg_t cfg,
    output ptd_pkg::res_t      res0,
    output ptd_pkg::res_t      res1,
    output logic [1:0]         res_count
);

    ptd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [63:0] shift_reg, shift_next;
    logic        swp_reg, swp_next;
    logic        nano_reg, nano_next;
    logic [15:0] copy_reg, copy_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] stc_reg, stc_next;
    logic [15:0] orc_reg, orc_next;

    // Working copies after an optional file-start clear
    ptd_pkg::phase_t ph;
    logic [4:0]  idx;
    logic [63:0] sh;
    logic        swp;
    logic        nano;
    logic [15:0] copy_cnt;
    logic [31:0] skip_cnt;
    logic [15:0] stc;
    logic [15:0] orc;

    logic [63:0] sh_in;
    logic [31:0] magic;
    logic [31:0] incl;
    logic [31:0] orig;
    logic [4:0]  idx_inc;
    logic        emit_a;
    logic [1:0]  kind_a;
    logic [7:0]  byte_a;
    logic        emit_end;

    // Next state and results
    always_comb
    begin
        if (file_start)
        begin
            ph       = ptd_pkg::PH_FILE;
            idx      = '0;
            sh       = '0;
            swp      = 1'b0;
            nano     = 1'b0;
            copy_cnt = '0;
            skip_cnt = '0;
            stc      = '0;
            orc      = '0;
        end
        else
        begin
            ph       = phase_reg;
            idx      = idx_reg;
            sh       = shift_reg;
            swp      = swp_reg;
            nano     = nano_reg;
            copy_cnt = copy_reg;
            skip_cnt = skip_reg;
            stc      = stc_reg;
            orc      = orc_reg;
        end

        phase_next = ph;
        idx_next   = idx;
        shift_next = sh;
        swp_next   = swp;
        nano_next  = nano;
        copy_next  = copy_cnt;
        skip_next  = skip_cnt;
        stc_next   = stc;
        orc_next   = orc;

        sh_in   = {sh[55:0], file_byte};
        idx_inc = 5'(idx + 5'd1);
        magic   = ptd_pkg::swap32(sh_in[31:0]);
        incl    = swp ? sh_in[63:32] : ptd_pkg::swap32(sh_in[63:32]);
        orig    = swp ? sh_in[31:0]  : ptd_pkg::swap32(sh_in[31:0]);

        emit_a   = 1'b0;
        kind_a   = ptd_pkg::KIND_PAYLOAD;
        byte_a   = '0;
        emit_end = 1'b0;

        unique case (ph)
            ptd_pkg::PH_FILE:
            begin
                shift_next = sh_in;
                if (idx == ptd_pkg::MAGIC_LAST_INDEX &&
                    magic != ptd_pkg::MAGIC_MICRO && magic != ptd_pkg::MAGIC_NANO &&
                    magic != ptd_pkg::MAGIC_MICRO_SWAP &&
                    magic != ptd_pkg::MAGIC_NANO_SWAP)
                begin
                    // bad magic: report once, then wait for the next file start
                    swp_next   = 1'b0;
                    nano_next  = 1'b0;
                    phase_next = ptd_pkg::PH_STUCK;
                    idx_next   = '0;
                    shift_next = '0;
                    emit_a     = 1'b1;
                    kind_a     = ptd_pkg::KIND_BAD_MAGIC;
                end
                else
                begin
                    if (idx == ptd_pkg::MAGIC_LAST_INDEX)
                    begin
                        swp_next  = (magic == ptd_pkg::MAGIC_MICRO_SWAP) ||
                                    (magic == ptd_pkg::MAGIC_NANO_SWAP);
                        nano_next = (magic == ptd_pkg::MAGIC_NANO) ||
                                    (magic == ptd_pkg::MAGIC_NANO_SWAP);
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= ptd_pkg::FILE_HEADER_BYTES)
                    begin
                        phase_next = ptd_pkg::PH_REC;
                        idx_next   = '0;
                        shift_next = '0;
                    end
                end
            end
            ptd_pkg::PH_REC:
            begin
                shift_next = sh_in;
                idx_next   = idx_inc;
                if (idx_inc >= ptd_pkg::RECORD_HEADER_BYTES)
                begin
                    // lengths from the last eight header bytes, clamped
                    stc_next  = (incl < {16'd0, cfg.max_copy_length}) ?
                                incl[15:0] : cfg.max_copy_length;
                    orc_next  = (orig < {16'd0, cfg.max_copy_length}) ?
                                orig[15:0] : cfg.max_copy_length;
                    skip_next = incl - {16'd0, stc_next};
                    copy_next = stc_next;
                    idx_next   = '0;
                    shift_next = '0;
                    if (stc_next != 16'd0)
                    begin
                        phase_next = ptd_pkg::PH_COPY;
                    end
                    else
                    begin
                        emit_end   = 1'b1;
                        phase_next = (skip_next != 32'd0) ? ptd_pkg::PH_SKIP :
                                                            ptd_pkg::PH_REC;
                    end
                end
            end
            ptd_pkg::PH_COPY:
            begin
                emit_a = 1'b1;
                kind_a = ptd_pkg::KIND_PAYLOAD;
                byte_a = file_byte;
                if (copy_cnt != 16'd0)
                begin
                    copy_next = copy_cnt - 16'd1;
                end
                if (copy_next == 16'd0)
                begin
                    emit_end   = 1'b1;
                    phase_next = (skip_cnt != 32'd0) ? ptd_pkg::PH_SKIP :
                                                       ptd_pkg::PH_REC;
                end
            end
            ptd_pkg::PH_SKIP:
            begin
                if (skip_cnt != 32'd0)
                begin
                    skip_next = skip_cnt - 32'd1;
                end
                if (skip_next == 32'd0)
                begin
                    phase_next = ptd_pkg::PH_REC;
                end
            end
            ptd_pkg::PH_STUCK:
            begin
                phase_next = ptd_pkg::PH_STUCK;
            end
            default:
            begin
                phase_next = ptd_pkg::PH_STUCK;
            end
        endcase

        // First result slot: payload or error item
        res0.record_kind   = kind_a;
        res0.payload_byte  = byte_a;
        res0.packet_length = '0;
        res0.pad_length    = '0;
        res0.pad_value     = cfg.fill_byte;
        res0.swapped_order = swp_next;
        res0.nano_stamps   = nano_next;
        res0.last_of_run   = !emit_end;

        // End record
        res1.record_kind   = ptd_pkg::KIND_END;
        res1.payload_byte  = '0;
        res1.packet_length = orc_next;
        res1.pad_length    = (orc_next > stc_next) ? 16'(orc_next - stc_next) : 16'd0;
        res1.pad_value     = cfg.fill_byte;
        res1.swapped_order = swp_next;
        res1.nano_stamps   = nano_next;
        res1.last_of_run   = 1'b1;

        // Compact: an end record alone goes to the first slot
        if (!emit_a)
        begin
            res0 = res1;
        end
        res_count = {1'b0, emit_a} + {1'b0, emit_end};
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ptd_pkg::PH_FILE;
            idx_reg   <= '0;
            shift_reg <= '0;
            swp_reg   <= 1'b0;
            nano_reg  <= 1'b0;
            copy_reg  <= '0;
            skip_reg  <= '0;
            stc_reg   <= '0;
            orc_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            swp_reg   <= swp_next;
            nano_reg  <= nano_next;
            copy_reg  <= copy_next;
            skip_reg  <= skip_next;
            stc_reg   <= stc_next;
            orc_reg   <= orc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pcap_trace_deframer_unit.sv
// Top level of the capture-trace deframer: stream ports, configuration
// registers and the two-entry result buffer. Depends on ptd_pkg, ptd_parser.
//
// Takes a classic capture-trace file one byte per item and returns payload
// items, packet end records and bad-magic error records. An input item is
// taken every cycle while the results drain one per cycle; the last stored
// byte of a packet yields a payload item and an end record, and the next
// byte waits until the single result port has delivered the first of the
// two from the two-entry result buffer. All parsing for a byte is done in
// the cycle it is taken. The user writes configuration through the cfg port
// while the block is idle (not enforced); no clearing pass follows reset.
`default_nettype none

module pcap_trace_deframer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] file_byte
    input  wire logic        s_tuser,   // [0] file_start
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] payload_byte, [23:8] packet_length, [39:24] pad_length,
    // [47:40] pad_value, [48] swapped_order, [49] nano_stamps, [55:50] zero
    output logic [55:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] record_kind
    output logic             m_tlast,   // last_of_run
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    ptd_pkg::cfg_t cfg_reg;
    ptd_pkg::res_t res0;
    ptd_pkg::res_t res1;
    logic [1:0]    res_count;

    ptd_pkg::res_t slot0_reg, slot0_next;
    ptd_pkg::res_t slot1_reg, slot1_next;
    logic [1:0]    cnt_reg, cnt_next;

    logic step;
    logic pop;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_copy_length <= ptd_pkg::MAX_COPY_RESET;
            cfg_reg.fill_byte       <= ptd_pkg::FILL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptd_pkg::CFG_MAX_COPY: cfg_reg.max_copy_length <= cfg_data;
                ptd_pkg::CFG_FILL:     cfg_reg.fill_byte       <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    // Handshakes
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign step     = s_tvalid && s_tready;

    ptd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .file_byte  (s_tdata),
        .file_start (s_tuser),
        .cfg        (cfg_reg),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    // Result buffer: load on a taken item, shift on a delivered item
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (step)
        begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = res_count;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = (cnt_reg == 2'd2) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Output packing
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = slot0_reg.record_kind;
    assign m_tlast  = slot0_reg.last_of_run;
    assign m_tdata  = {6'd0, slot0_reg.nano_stamps, slot0_reg.swapped_order,
                       slot0_reg.pad_value, slot0_reg.pad_length,
                       slot0_reg.packet_length, slot0_reg.payload_byte};

endmodule

`default_nettype wire

### sim/ptd_result_checker.sv
// Result checker for the capture-trace deframer: watches the input, result and
// configuration channels, predicts the result items and compares them.
// Depends on ptd_pkg for the result struct, phase codes and constants.
`timescale 1ns / 100ps

module ptd_result_checker
    import ptd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          error_count,
    output int          outstanding
);

    // Mirror of the configuration registers
    logic [15:0] copy_limit;
    logic [7:0]  pad_fill;

    // Mirror of the parser state
    phase_t      phase;
    logic [4:0]  hdr_idx;
    logic [63:0] hdr_shift;
    logic        swapped;
    logic        nano;
    logic [15:0] copy_left;
    logic [31:0] skip_left;
    logic [15:0] stored_cl;
    logic [15:0] orig_cl;

    res_t expected_records[$];

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        byte_reverse = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [15:0] clamp_len(input logic [31:0] len);
        clamp_len = (len < {16'd0, copy_limit}) ? len[15:0] : copy_limit;
    endfunction

    function automatic res_t make_record(input logic [1:0] kind, input logic [7:0] data,
                                         input logic [15:0] len, input logic [15:0] pad);
        res_t r;
        r.record_kind   = kind;
        r.payload_byte  = data;
        r.packet_length = len;
        r.pad_length    = pad;
        r.pad_value     = pad_fill;
        r.swapped_order = swapped;
        r.nano_stamps   = nano;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Packet end record; pad only when the original is longer
    function automatic res_t end_record();
        logic [15:0] pad;
        pad = (orig_cl > stored_cl) ? orig_cl - stored_cl : 16'd0;
        return make_record(KIND_END, 8'd0, orig_cl, pad);
    endfunction

    task automatic clear_parse();
        phase     = PH_FILE;
        hdr_idx   = '0;
        hdr_shift = '0;
        swapped   = 1'b0;
        nano      = 1'b0;
        copy_left = '0;
        skip_left = '0;
        stored_cl = '0;
        orig_cl   = '0;
    endtask

    // Advance the parser by one trace byte and queue the records it yields
    task automatic deframe_byte(input logic [7:0] b, input logic first);
        res_t        recs[2];
        int          n;
        logic        bad;
        logic [31:0] word;
        logic [31:0] stored_len;
        logic [31:0] wire_len;
        n = 0;
        bad = 1'b0;
        if (first)
            clear_parse();
        case (phase)
            PH_FILE:
            begin
                hdr_shift = {hdr_shift[55:0], b};
                if (hdr_idx == MAGIC_LAST_INDEX)
                begin
                    word = byte_reverse(hdr_shift[31:0]);
                    if (word == MAGIC_MICRO || word == MAGIC_NANO)
                    begin
                        swapped = 1'b0;
                        nano    = (word == MAGIC_NANO);
                    end
                    else if (word == MAGIC_MICRO_SWAP || word == MAGIC_NANO_SWAP)
                    begin
                        swapped = 1'b1;
                        nano    = (word == MAGIC_NANO_SWAP);
                    end
                    else
                    begin
                        // unknown magic: error record, then stuck until next file
                        swapped   = 1'b0;
                        nano      = 1'b0;
                        phase     = PH_STUCK;
                        hdr_idx   = '0;
                        hdr_shift = '0;
                        recs[n]   = make_record(KIND_BAD_MAGIC, 8'd0, 16'd0, 16'd0);
                        n++;
                        bad = 1'b1;
                    end
                end
                if (!bad)
                begin
                    hdr_idx = hdr_idx + 5'd1;
                    if (hdr_idx >= FILE_HEADER_BYTES)
                    begin
                        phase     = PH_REC;
                        hdr_idx   = '0;
                        hdr_shift = '0;
                    end
                end
            end
            PH_REC:
            begin
                hdr_shift = {hdr_shift[55:0], b};
                hdr_idx = hdr_idx + 5'd1;
                if (hdr_idx >= RECORD_HEADER_BYTES)
                begin
                    stored_len = hdr_shift[63:32];
                    wire_len   = hdr_shift[31:0];
                    if (!swapped)
                    begin
                        stored_len = byte_reverse(stored_len);
                        wire_len   = byte_reverse(wire_len);
                    end
                    stored_cl = clamp_len(stored_len);
                    orig_cl   = clamp_len(wire_len);
                    skip_left = stored_len - {16'd0, stored_cl};
                    copy_left = stored_cl;
                    hdr_idx   = '0;
                    hdr_shift = '0;
                    if (copy_left != 0)
                        phase = PH_COPY;
                    else
                    begin
                        recs[n] = end_record();
                        n++;
                        phase = (skip_left != 0) ? PH_SKIP : PH_REC;
                    end
                end
            end
            PH_COPY:
            begin
                recs[n] = make_record(KIND_PAYLOAD, b, 16'd0, 16'd0);
                n++;
                if (copy_left != 0)
                    copy_left = copy_left - 16'd1;
                if (copy_left == 0)
                begin
                    recs[n] = end_record();
                    n++;
                    phase = (skip_left != 0) ? PH_SKIP : PH_REC;
                end
            end
            PH_SKIP:
            begin
                if (skip_left != 0)
                    skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    phase = PH_REC;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            recs[i].last_of_run = (i == n - 1);
            expected_records.push_back(recs[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Compare one result item with the oldest expectation
    task automatic check_result();
        res_t got;
        res_t want;
        got.record_kind   = m_tuser;
        got.payload_byte  = m_tdata[7:0];
        got.packet_length = m_tdata[23:8];
        got.pad_length    = m_tdata[39:24];
        got.pad_value     = m_tdata[47:40];
        got.swapped_order = m_tdata[48];
        got.nano_stamps   = m_tdata[49];
        got.last_of_run   = m_tlast;
        if (expected_records.size() == 0)
            report_mismatch("unexpected result item, kind", 32'(got.record_kind), 32'd0);
        else
        begin
            want = expected_records.pop_front();
            if (got.record_kind !== want.record_kind)
                report_mismatch("record_kind", 32'(got.record_kind),
                                32'(want.record_kind));
            if (got.payload_byte !== want.payload_byte)
                report_mismatch("payload_byte", 32'(got.payload_byte),
                                32'(want.payload_byte));
            if (got.packet_length !== want.packet_length)
                report_mismatch("packet_length", 32'(got.packet_length),
                                32'(want.packet_length));
            if (got.pad_length !== want.pad_length)
                report_mismatch("pad_length", 32'(got.pad_length),
                                32'(want.pad_length));
            if (got.pad_value !== want.pad_value)
                report_mismatch("pad_value", 32'(got.pad_value),
                                32'(want.pad_value));
            if (got.swapped_order !== want.swapped_order)
                report_mismatch("swapped_order", 32'(got.swapped_order),
                                32'(want.swapped_order));
            if (got.nano_stamps !== want.nano_stamps)
                report_mismatch("nano_stamps", 32'(got.nano_stamps),
                                32'(want.nano_stamps));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 32'(got.last_of_run),
                                32'(want.last_of_run));
        end
    endtask

    // Sample all channels at the rising edge; predictions go in before the compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_limit = MAX_COPY_RESET;
            pad_fill   = FILL_RESET;
            clear_parse();
            expected_records.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_COPY: copy_limit = cfg_data;
                    CFG_FILL:     pad_fill   = cfg_data[7:0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_result();
            outstanding = expected_records.size();
        end
    end

endmodule

### sim/testbench.sv
// Top of the deframer testbench: clock, reset, trace-byte stimulus, result
// backpressure, watchdog and verdict. Depends on ptd_pkg, the deframer RTL
// and ptd_result_checker.
`timescale 1ns / 100ps

module testbench;
    import ptd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SEGMENT_BYTES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int mismatches;
    int pending;
    int src_idle = 0;
    int snk_idle = 0;
    int bytes_sent = 0;
    int stall_cycles = 0;
    bit file_big = 1'b0;

    pcap_trace_deframer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptd_result_checker u_result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (mismatches),
        .outstanding (pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result backpressure
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // Watchdog: no item accepted on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no progress", $time);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // One trace byte; entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Register write once all results are out and the parser has settled
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Header field in the byte order of the current file
    task automatic push_word(input logic [31:0] w);
        if (file_big)
        begin
            push_byte(w[31:24], 1'b0);
            push_byte(w[23:16], 1'b0);
            push_byte(w[15:8], 1'b0);
            push_byte(w[7:0], 1'b0);
        end
        else
        begin
            push_byte(w[7:0], 1'b0);
            push_byte(w[15:8], 1'b0);
            push_byte(w[23:16], 1'b0);
            push_byte(w[31:24], 1'b0);
        end
    endtask

    // File header, possibly cut short; magic goes out low byte first
    task automatic send_file_header(input logic [31:0] magic, input int hdr_len);
        file_big = (magic == MAGIC_MICRO_SWAP || magic == MAGIC_NANO_SWAP);
        for (int i = 0; i < hdr_len; i++)
        begin
            if (i < 4)
                push_byte(magic[8*i +: 8], i == 0);
            else
                push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Record header with random timestamps, then data_count stored bytes
    task automatic send_packet(input logic [31:0] incl, input logic [31:0] orig,
                               input int data_count);
        repeat (8) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_word(incl);
        push_word(orig);
        repeat (data_count) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // One random file: mostly well formed, sometimes noise or cut short
    task automatic send_random_file();
        logic [31:0] magic;
        logic [31:0] incl;
        logic [31:0] orig;
        int          npk;
        int          data_count;
        bit          cut;
        cut = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            // garbage magic, then bytes the block should ignore
            push_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(2, 10)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        case ($urandom_range(0, 3))
            0:       magic = MAGIC_MICRO;
            1:       magic = MAGIC_NANO;
            2:       magic = MAGIC_MICRO_SWAP;
            default: magic = MAGIC_NANO_SWAP;
        endcase
        if ($urandom_range(0, 19) == 0)
        begin
            send_file_header(magic, $urandom_range(1, 23));
            return;
        end
        send_file_header(magic, 24);
        npk = $urandom_range(1, 5);
        for (int k = 0; k < npk && !cut; k++)
        begin
            case ($urandom_range(0, 19))
                0:       incl = 32'd0;
                1:       incl = $urandom;
                2:       incl = $urandom_range(100, 300);
                default: incl = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 5))
                0:       orig = $urandom;
                1:       orig = incl - $urandom_range(0, (incl < 16) ? incl : 16);
                2:       orig = incl + $urandom_range(1, 40);
                default: orig = incl;
            endcase
            if (incl > 400)
            begin
                // too long to stream: restart the file partway through
                cut = 1'b1;
                data_count = $urandom_range(0, 10);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                cut = 1'b1;
                data_count = $urandom_range(0, incl);
            end
            else
                data_count = incl;
            send_packet(incl, orig, data_count);
        end
    endtask

    initial
    begin
        logic [15:0] limit_val;
        int          seg_end;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part
        src_idle = 23;
        snk_idle = 88;
        // bad magic, then bytes ignored while stuck
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // little-endian micro file at reset settings: plain, empty, original shorter
        send_file_header(MAGIC_MICRO, 24);
        send_packet(32'd3, 32'd3, 3);
        send_packet(32'd0, 32'd5, 0);
        send_packet(32'd5, 32'd2, 5);
        // small buffer: clamp with skipped bytes, then padding
        write_reg(CFG_MAX_COPY, 16'd4);
        write_reg(CFG_FILL, 16'h00A5);
        send_file_header(MAGIC_NANO_SWAP, 24);
        send_packet(32'd7, 32'd9, 7);
        send_packet(32'd2, 32'd10, 2);
        // zero buffer: every stored byte skipped
        write_reg(CFG_MAX_COPY, 16'd0);
        send_file_header(MAGIC_MICRO_SWAP, 24);
        send_packet(32'd3, 32'd3, 3);
        // largest buffer and lengths; new file starts mid-packet
        write_reg(CFG_MAX_COPY, 16'hFFFF);
        write_reg(CFG_FILL, 16'h00FF);
        send_file_header(MAGIC_NANO, 24);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);

        // Random part in three idling modes
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    src_idle = 23;
                    snk_idle = 88;
                end
                1:
                begin
                    src_idle = 88;
                    snk_idle = 23;
                end
                default:
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            for (int seg = 0; seg < 5; seg++)
            begin
                case ($urandom_range(0, 5))
                    0:       limit_val = 16'd0;
                    1:       limit_val = 16'd1;
                    2:       limit_val = 16'hFFFF;
                    3:       limit_val = MAX_COPY_RESET;
                    default: limit_val = 16'($urandom_range(2, 32));
                endcase
                write_reg(CFG_MAX_COPY, limit_val);
                write_reg(CFG_FILL, {8'd0, 8'($urandom_range(0, 255))});
                seg_end = bytes_sent + SEGMENT_BYTES;
                while (bytes_sent < seg_end)
                    send_random_file();
            end
        end

        // Drain and verdict
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/ptd_pkg.sv
rtl/ptd_parser.sv
rtl/pcap_trace_deframer_unit.sv
sim/ptd_result_checker.sv
sim/testbench.sv
